// File: src/dis_pkg.sv
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types and constants for the debounced interlock stepper sweep.
// ----------------------------------------------------------------------------
package dis_pkg;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE_TICKS = 2'd0,
		REG_STEPS_PER_REV  = 2'd1,
		REG_DWELL_TICKS    = 2'd2,
		REG_STEP_PERIOD    = 2'd3
	} cfg_reg_t;

	localparam int unsigned CFG_DATA_W = 16;

	// Reset values of the configuration registers
	localparam logic [15:0] DEBOUNCE_RST = 16'd500;
	localparam logic [15:0] STEPS_RST    = 16'd2048;
	localparam logic [15:0] DWELL_RST    = 16'd2000;
	localparam logic [7:0]  PERIOD_RST   = 8'd3;

	// Saturation limits
	localparam logic [16:0] STABLE_MAX = 17'h1FFFF;
	localparam logic [15:0] DWELL_MAX  = 16'hFFFF;

	// Sweep phases
	typedef enum logic [1:0] {
		PH_CW     = 2'd0,
		PH_DWELL0 = 2'd1,
		PH_CCW    = 2'd2,
		PH_DWELL1 = 2'd3
	} phase_t;

	// Live configuration
	typedef struct packed {
		logic [15:0] debounce_ticks;
		logic [15:0] steps_per_rev;
		logic [15:0] dwell_ticks;
		logic [7:0]  step_period;
	} cfg_t;

	// Debounce status handed to the sequencer and the result
	typedef struct packed {
		logic flag;
		logic changed;
	} deb_t;

	// One result item
	typedef struct packed {
		logic       relay_active;
		logic       state_changed;
		logic       step_pulse;
		logic       step_reverse;
		logic [1:0] sweep_phase;
	} res_t;

endpackage

// File: src/dis_regs.sv
// ----------------------------------------------------------------------------
// dis_regs
// Configuration register file, written through the config channel.
// ----------------------------------------------------------------------------
module dis_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [dis_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [dis_pkg::CFG_DATA_W-1:0] wr_data,
	output dis_pkg::cfg_t                  cfg
);
	import dis_pkg::*;

	cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= DEBOUNCE_RST;
			cfg_q.steps_per_rev  <= STEPS_RST;
			cfg_q.dwell_ticks    <= DWELL_RST;
			cfg_q.step_period    <= PERIOD_RST;
		end else if (wr_en) begin
			unique case (cfg_reg_t'(wr_index))
				REG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= wr_data;
				REG_STEPS_PER_REV:  cfg_q.steps_per_rev  <= wr_data;
				REG_DWELL_TICKS:    cfg_q.dwell_ticks    <= wr_data;
				REG_STEP_PERIOD:    cfg_q.step_period    <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/dis_debounce.sv
// ----------------------------------------------------------------------------
// dis_debounce
// Level debouncer with a saturating stable counter and the obstacle flag.
// ----------------------------------------------------------------------------
module dis_debounce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        advance,
	input  logic        level,
	input  logic [15:0] debounce_ticks,
	output dis_pkg::deb_t deb
);
	import dis_pkg::*;

	logic        last_level_q;
	logic [16:0] stable_q;
	logic        flag_q;

	logic [16:0] stable_nx;
	logic        accept_lvl;

	// Restart on a level change, otherwise count up to saturation
	always_comb begin
		if (level != last_level_q) begin
			stable_nx = '0;
		end else if (stable_q < STABLE_MAX) begin
			stable_nx = stable_q + 17'd1;
		end else begin
			stable_nx = stable_q;
		end
		accept_lvl  = (stable_nx > {1'b0, debounce_ticks}) && (level != flag_q);
		deb.changed = accept_lvl;
		deb.flag    = accept_lvl ? level : flag_q;
	end

	// Hold state until an item is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			stable_q     <= '0;
			flag_q       <= 1'b0;
		end else if (advance) begin
			last_level_q <= level;
			stable_q     <= stable_nx;
			flag_q       <= deb.flag;
		end
	end

endmodule

// File: src/dis_sweep.sv
// ----------------------------------------------------------------------------
// dis_sweep
// Four-phase sweep sequencer: cw steps, dwell, ccw steps, dwell.
// ----------------------------------------------------------------------------
module dis_sweep (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	input  logic          obstacle,
	input  dis_pkg::cfg_t cfg,
	output logic          step_pulse,
	output logic          step_reverse,
	output logic [1:0]    sweep_phase
);
	import dis_pkg::*;

	phase_t      phase_q, phase_nx;
	logic [15:0] step_q, step_nx;
	logic [15:0] dwell_q, dwell_nx;
	logic [7:0]  rate_q, rate_nx;

	logic [7:0]  period;
	logic [8:0]  rate_inc;
	logic [16:0] step_inc;
	logic [15:0] dwell_inc;

	// Next phase and counters for one tick
	always_comb begin
		period    = (cfg.step_period == 8'd0) ? 8'd1 : cfg.step_period;
		rate_inc  = {1'b0, rate_q} + 9'd1;
		step_inc  = {1'b0, step_q} + 17'd1;
		dwell_inc = (phase_q[0] && (dwell_q < DWELL_MAX)) ? dwell_q + 16'd1 : dwell_q;

		phase_nx     = phase_q;
		step_nx      = step_q;
		dwell_nx     = dwell_inc;
		rate_nx      = rate_q;
		step_pulse   = 1'b0;
		step_reverse = 1'b0;

		if (!obstacle) begin
			if (!phase_q[0]) begin
				if (rate_inc >= {1'b0, period}) begin
					rate_nx      = '0;
					step_pulse   = 1'b1;
					step_reverse = (phase_q == PH_CCW);
					if (step_inc >= {1'b0, cfg.steps_per_rev}) begin
						step_nx  = '0;
						dwell_nx = '0;
						phase_nx = phase_t'(phase_q + 2'd1);
					end else begin
						step_nx = step_inc[15:0];
					end
				end else begin
					rate_nx = rate_inc[7:0];
				end
			end else if (dwell_inc >= cfg.dwell_ticks) begin
				rate_nx  = '0;
				phase_nx = phase_t'(phase_q + 2'd1);
			end
		end
		sweep_phase = phase_nx;
	end

	// Advance on each taken item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CW;
			step_q  <= '0;
			dwell_q <= '0;
			rate_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_nx;
			step_q  <= step_nx;
			dwell_q <= dwell_nx;
			rate_q  <= rate_nx;
		end
	end

endmodule

// File: src/dis_out.sv
// ----------------------------------------------------------------------------
// dis_out
// Result register with a skid entry; stall toward the input is registered.
// ----------------------------------------------------------------------------
module dis_out (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  dis_pkg::res_t push_data,
	output logic          full,
	output logic          out_valid,
	input  logic          out_stall,
	output dis_pkg::res_t out_data
);
	import dis_pkg::*;

	logic main_v_q, skid_v_q;
	res_t main_q, skid_q;
	logic pop;

	assign pop       = main_v_q && !out_stall;
	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	// Track occupancy of both entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				main_v_q <= push;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end
	end

	// Move payload: skid drains into main, new items fill the free entry
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_v_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

// File: src/debounced_interlock_stepper_sweep.sv
// ----------------------------------------------------------------------------
// debounced_interlock_stepper_sweep
// Debounced obstacle interlock driving a relay, with a back-and-forth
// stepper sweep that pauses while an obstacle is present.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+--------------------------------------------
//  in      | in_valid / in_stall | sensor_level
//  out     | out_valid/out_stall | relay_active, state_changed, step_pulse,
//          |                     | step_reverse, sweep_phase
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One tick item per clock while in_stall is low; its result is registered
//  in the output entries. All state updates in the cycle the item is taken.
//  A two-entry output (result register plus skid) keeps input stall a
//  registered signal; input stalls only when both entries are full.
//  Reset restores the register defaults and clears all sweep and debounce
//  state; no warm-up is needed. Config writes are always ready.
// ----------------------------------------------------------------------------
module debounced_interlock_stepper_sweep (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           sensor_level,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           relay_active,
	output logic                           state_changed,
	output logic                           step_pulse,
	output logic                           step_reverse,
	output logic [1:0]                     sweep_phase,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dis_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dis_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dis_pkg::*;

	cfg_t cfg;
	deb_t deb;
	res_t res, res_out;
	logic take;
	logic out_full;
	logic pulse, rev;
	logic [1:0] phase;

	assign cfg_ready = 1'b1;
	assign in_stall  = out_full;
	assign take      = in_valid && !out_full;

	dis_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	dis_debounce u_debounce (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (take),
		.level          (sensor_level),
		.debounce_ticks (cfg.debounce_ticks),
		.deb            (deb)
	);

	dis_sweep u_sweep (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (take),
		.obstacle     (deb.flag),
		.cfg          (cfg),
		.step_pulse   (pulse),
		.step_reverse (rev),
		.sweep_phase  (phase)
	);

	// Assemble the result item
	always_comb begin
		res.relay_active  = deb.flag;
		res.state_changed = deb.changed;
		res.step_pulse    = pulse;
		res.step_reverse  = rev;
		res.sweep_phase   = phase;
	end

	dis_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.push_data (res),
		.full      (out_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (res_out)
	);

	assign relay_active  = res_out.relay_active;
	assign state_changed = res_out.state_changed;
	assign step_pulse    = res_out.step_pulse;
	assign step_reverse  = res_out.step_reverse;
	assign sweep_phase   = res_out.sweep_phase;

endmodule
